// ===== sv/rrq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the ranked request queue.
// No dependencies; imported by rrq_store and the top level.
package rrq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int RANK_W      = 16;
   localparam int SRC_W       = 8;
   localparam int BATCH_W     = 6;
   localparam int POS_W       = 6;
   localparam int RES_W       = 6;
   localparam int SCAN_W      = ((POS_W > RES_W) ? POS_W : RES_W) + 1;

   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;
   localparam logic [1:0] KIND_DELETE  = 2'd3;

   localparam logic [1:0] OP_NOP     = 2'd0;
   localparam logic [1:0] OP_INSERT  = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_SHIFT   = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [RANK_W-1:0] rank;
      logic [SRC_W-1:0]  source;
   } store_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0]       count;
      logic                   found;
      logic [IDX_W-1:0]       match_index;
      logic [QUEUE_DEPTH-1:0] pending;
   } store_stat_type;

endpackage

// ===== sv/ranked_request_queue_multi_resource_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ranked request queue: command port, sequencer, result strobe.
// Depends on rrq_pkg and rrq_store.

// Commands are taken when start is high and busy is low; each yields exactly one
// result, shown for a single cycle with rsp_valid, which the receiver cannot stall.
// Insert and release finish in the execute state; a found query walks back in residue
// steps from its position by resource_count (one subtract per cycle in a shared scan
// unit) until below zero or a pending entry; a delete that succeeds shifts the queue
// down one entry per cycle until batch_count entries are gone. rsp_valid is high in
// the first cycle with busy low again, and a new command may be taken in that cycle.
// csr writes are always ready and must be issued only while the block is idle.
module ranked_request_queue_multi_resource_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [rrq_pkg::RANK_W-1:0]   req_rank,
   input  logic [rrq_pkg::SRC_W-1:0]    req_source,
   input  logic [rrq_pkg::BATCH_W-1:0]  req_batch_count,
   output logic                         rsp_valid,
   output logic signed [rrq_pkg::POS_W-1:0] rsp_position,
   output logic                         rsp_resource_free,
   output logic                         rsp_deleted,
   output logic                         rsp_overflow,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rrq_pkg::RES_W-1:0]    csr_resource_count
);
   import rrq_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_SHIFT = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [SRC_W-1:0]   source_ff, source_in;
   logic [BATCH_W-1:0] batch_ff, batch_in;
   logic [BATCH_W-1:0] steps_ff, steps_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [RES_W-1:0]   res_count_ff;
   logic               valid_ff, valid_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic               free_ff, free_in;
   logic               deleted_ff, deleted_in;
   logic               overflow_ff, overflow_in;

   store_ctrl_type     ctrl;
   store_stat_type     stat;
   logic [RES_W-1:0]   res_eff;
   logic               head_pending;
   logic               del_ok;
   logic               accept;

   rrq_store u_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign res_eff   = (res_count_ff == '0) ? RES_W'(1) : res_count_ff;

   always_comb begin
      head_pending = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (stat.pending[i] && (i < int'(batch_ff))) begin
            head_pending = 1'b1;
         end
      end
      del_ok = (batch_ff != '0) &&
               ((BATCH_W + CNT_W)'(batch_ff) <= (BATCH_W + CNT_W)'(stat.count)) &&
               !head_pending;
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      rank_in     = rank_ff;
      source_in   = source_ff;
      batch_in    = batch_ff;
      steps_in    = steps_ff;
      scan_in     = scan_ff;
      valid_in    = 1'b0;
      position_in = position_ff;
      free_in     = free_ff;
      deleted_in  = deleted_ff;
      overflow_in = overflow_ff;
      ctrl.op     = OP_NOP;
      ctrl.rank   = rank_ff;
      ctrl.source = source_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in     = req_kind;
               rank_in     = req_rank;
               source_in   = req_source;
               batch_in    = req_batch_count;
               position_in = '0;
               free_in     = 1'b0;
               deleted_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (kind_ff)
               KIND_INSERT: begin
                  if (stat.count == CNT_W'(QUEUE_DEPTH)) begin
                     overflow_in = 1'b1;
                  end else begin
                     ctrl.op = OP_INSERT;
                  end
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
               KIND_RELEASE: begin
                  ctrl.op  = OP_RELEASE;
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
               KIND_QUERY: begin
                  if (!stat.found) begin
                     position_in = '1;
                     valid_in    = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     position_in = POS_W'(stat.match_index);
                     free_in     = 1'b1;
                     scan_in     = SCAN_W'(stat.match_index) - SCAN_W'(res_eff);
                     state_in    = ST_SCAN;
                  end
               end
               KIND_DELETE: begin
                  if (del_ok) begin
                     steps_in = batch_ff;
                     state_in = ST_SHIFT;
                  end else begin
                     valid_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            // walk back by resource_count until below zero or a pending entry
            if (scan_ff[SCAN_W-1]) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.pending[scan_ff[IDX_W-1:0]]) begin
               free_in  = 1'b0;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff - SCAN_W'(res_eff);
            end
         end
         ST_SHIFT: begin
            ctrl.op  = OP_SHIFT;
            steps_in = steps_ff - BATCH_W'(1);
            if (steps_ff == BATCH_W'(1)) begin
               deleted_in = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= 1'b0;
         res_count_ff <= RES_W'(1);
         steps_ff     <= '0;
         scan_ff      <= '0;
         kind_ff      <= KIND_INSERT;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         steps_ff <= steps_in;
         scan_ff  <= scan_in;
         kind_ff  <= kind_in;
         if (csr_valid && csr_ready) begin
            res_count_ff <= csr_resource_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      rank_ff     <= rank_in;
      source_ff   <= source_in;
      batch_ff    <= batch_in;
      position_ff <= position_in;
      free_ff     <= free_in;
      deleted_ff  <= deleted_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_position      = position_ff;
   assign rsp_resource_free = free_ff;
   assign rsp_deleted       = deleted_ff;
   assign rsp_overflow      = overflow_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (int'(stat.count) <= QUEUE_DEPTH))
      else $error("entry count above queue depth");

endmodule

// ===== sv/rrq_store.sv =====
`timescale 1ns / 1ps
// Entry storage of the ranked request queue: sorted insert, release, shift by one,
// plus per-entry source match. Depends on rrq_pkg.
module rrq_store (
   input  logic                    clock,
   input  logic                    reset,
   input  rrq_pkg::store_ctrl_type ctrl,
   output rrq_pkg::store_stat_type stat
);
   import rrq_pkg::*;

   logic [RANK_W-1:0]      entry_rank_ff   [QUEUE_DEPTH];
   logic [SRC_W-1:0]       entry_source_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] pending_ff, pending_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic [QUEUE_DEPTH-1:0] valid, le, hit, move, put;
   logic                   found;
   logic [IDX_W-1:0]       match_index;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid[i] = i < int'(count_ff);
         le[i]    = valid[i] && (entry_rank_ff[i] <= ctrl.rank);
         hit[i]   = pending_ff[i] && (entry_source_ff[i] == ctrl.source);
      end
   end

   always_comb begin
      found       = |hit;
      match_index = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) begin
            match_index = IDX_W'(i);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
         logic [RANK_W-1:0] prev_rank, next_rank;
         logic [SRC_W-1:0]  prev_source, next_source;
         logic              prev_pending, next_pending, prefix;

         if (g == 0) begin : g_head
            assign prev_rank    = '0;
            assign prev_source  = '0;
            assign prev_pending = 1'b0;
            assign prefix       = 1'b1;
            assign move[g]      = 1'b0;
         end else begin : g_body
            assign prev_rank    = entry_rank_ff[g-1];
            assign prev_source  = entry_source_ff[g-1];
            assign prev_pending = pending_ff[g-1];
            assign prefix       = le[g-1];
            assign move[g]      = valid[g-1] && !le[g-1];
         end

         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_rank    = '0;
            assign next_source  = '0;
            assign next_pending = 1'b0;
         end else begin : g_inner
            assign next_rank    = entry_rank_ff[g+1];
            assign next_source  = entry_source_ff[g+1];
            assign next_pending = pending_ff[g+1];
         end

         assign put[g] = prefix && !le[g];

         always_comb begin
            pending_in[g] = pending_ff[g];
            case (ctrl.op)
               OP_INSERT: begin
                  if (move[g]) begin
                     pending_in[g] = prev_pending;
                  end else if (put[g]) begin
                     pending_in[g] = 1'b1;
                  end
               end
               OP_RELEASE: begin
                  if (found && (match_index == IDX_W'(g))) begin
                     pending_in[g] = 1'b0;
                  end
               end
               OP_SHIFT: begin
                  pending_in[g] = next_pending;
               end
               default: begin
                  pending_in[g] = pending_ff[g];
               end
            endcase
         end

         always_ff @(posedge clock) begin
            case (ctrl.op)
               OP_INSERT: begin
                  if (move[g]) begin
                     entry_rank_ff[g]   <= prev_rank;
                     entry_source_ff[g] <= prev_source;
                  end else if (put[g]) begin
                     entry_rank_ff[g]   <= ctrl.rank;
                     entry_source_ff[g] <= ctrl.source;
                  end
               end
               OP_SHIFT: begin
                  entry_rank_ff[g]   <= next_rank;
                  entry_source_ff[g] <= next_source;
               end
               default: begin
               end
            endcase
         end
      end
   endgenerate

   always_comb begin
      case (ctrl.op)
         OP_INSERT: count_in = count_ff + CNT_W'(1);
         OP_SHIFT:  count_in = count_ff - CNT_W'(1);
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   assign stat.count       = count_ff;
   assign stat.found       = found;
   assign stat.match_index = match_index;
   assign stat.pending     = pending_ff;

endmodule
